FILE: design/sir_pkg.sv
// ----------------------------------------------------------------------------
// sir_pkg: shared types and codes for the sorted insert / rank select block
// Request and status codes, field widths and the per-cell control bundle.
// ----------------------------------------------------------------------------
package sir_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned RANK_W   = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_AVERAGE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;

  // control seen by one cell of the row
  typedef struct packed {
    logic   insert_en;
    logic   occupied;
    logic   pick_a;
    logic   pick_b;
    value_t new_value;
  } cell_ctrl_t;

endpackage

FILE: design/sir_cell.sv
// ----------------------------------------------------------------------------
// sir_cell: one storage cell of the sorted row
// Holds one value, compares it with an incoming value and either keeps it,
// takes the incoming value or takes its left neighbor's value on insert.
// ----------------------------------------------------------------------------
module sir_cell (
  input  logic                clk,
  input  sir_pkg::cell_ctrl_t ctrl,
  input  sir_pkg::value_t     left_value,
  input  logic                left_greater,
  output sir_pkg::value_t     value,
  output logic                greater,
  output sir_pkg::value_t     pick_a_value,
  output sir_pkg::value_t     pick_b_value
);

  sir_pkg::value_t value_r;
  sir_pkg::value_t value_nxt;

  // prefix of the row that stays put: occupied and strictly larger
  assign greater = ctrl.occupied && (value_r > ctrl.new_value);

  always_comb begin
    value_nxt = value_r;
    if (ctrl.insert_en && !greater) begin
      value_nxt = left_greater ? ctrl.new_value : left_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value        = value_r;
  assign pick_a_value = ctrl.pick_a ? value_r : '0;
  assign pick_b_value = ctrl.pick_b ? value_r : '0;

endmodule

FILE: design/sorted_insert_rank_select_top.sv
// ----------------------------------------------------------------------------
// sorted_insert_rank_select_top: sorted store with rank and average reads
// Row of CAPACITY cells kept in descending order, with a small controller.
// ----------------------------------------------------------------------------
// Each transaction goes from start to the out_valid strobe through these
// steps in order: latch the request; let the cell row shift an insert into
// place or drive the chosen ranks onto the select bus; form the average and
// register the result. busy is low again in the cycle that shows out_valid,
// and a new transaction can start in that cycle; start is ignored while
// busy. The result is presented for a single cycle and must be taken then.
module sorted_insert_rank_select_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [sir_pkg::REQ_W-1:0]          in_req_type,
  input  logic signed [sir_pkg::VALUE_W-1:0] in_sample_value,
  input  logic [sir_pkg::RANK_W-1:0]         in_rank_index,
  output logic                               out_valid,
  output logic signed [sir_pkg::VALUE_W-1:0] out_result_value,
  output logic [sir_pkg::STATUS_W-1:0]       out_status_code,
  output logic [sir_pkg::COUNT_W-1:0]        out_entry_count
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  // compare width wide enough for count and rank + 1
  localparam int unsigned IW = (CW > sir_pkg::COUNT_W) ? CW : sir_pkg::COUNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [sir_pkg::REQ_W-1:0] req_r;
  sir_pkg::value_t           sample_r;
  logic [sir_pkg::RANK_W-1:0] rank_r;
  logic [sir_pkg::STATUS_W-1:0] st_r, st_nxt;
  sir_pkg::value_t sel_a_r, sel_b_r;
  sir_pkg::value_t result_r;
  logic [sir_pkg::STATUS_W-1:0] status_r;
  logic [sir_pkg::COUNT_W-1:0]  ecount_r;

  logic accept;
  logic [IW-1:0] count_w, rank_w, rank1_w;
  logic full;
  logic insert_en;

  sir_pkg::cell_ctrl_t ctrl     [CAPACITY];
  sir_pkg::value_t     cell_val [CAPACITY];
  sir_pkg::value_t     pa_val   [CAPACITY];
  sir_pkg::value_t     pb_val   [CAPACITY];
  logic                cell_gt  [CAPACITY];
  sir_pkg::value_t     sel_a, sel_b;

  logic signed [sir_pkg::VALUE_W:0] avg_sum;
  logic [CW+sir_pkg::COUNT_W-1:0]   count_ext;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign count_w = IW'(count_r);
  assign rank_w  = IW'(rank_r);
  assign rank1_w = rank_w + IW'(1);
  assign full    = (count_w >= IW'(CAPACITY));
  assign insert_en = (state_r == S_EXEC) && (req_r == sir_pkg::REQ_INSERT) && !full;

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign ctrl[i].insert_en = insert_en;
    assign ctrl[i].occupied  = (IW'(i) < count_w);
    assign ctrl[i].pick_a    = (IW'(i) == rank_w);
    assign ctrl[i].pick_b    = (IW'(i) == rank1_w);
    assign ctrl[i].new_value = sample_r;

    if (i == 0) begin : g_head
      sir_cell u_cell (
        .clk          (clk),
        .ctrl         (ctrl[i]),
        .left_value   (sample_r),
        .left_greater (1'b1),
        .value        (cell_val[i]),
        .greater      (cell_gt[i]),
        .pick_a_value (pa_val[i]),
        .pick_b_value (pb_val[i])
      );
    end else begin : g_body
      sir_cell u_cell (
        .clk          (clk),
        .ctrl         (ctrl[i]),
        .left_value   (cell_val[i-1]),
        .left_greater (cell_gt[i-1]),
        .value        (cell_val[i]),
        .greater      (cell_gt[i]),
        .pick_a_value (pa_val[i]),
        .pick_b_value (pb_val[i])
      );
    end
  end

  // one-hot select bus, each cell drives zero unless picked
  always_comb begin
    sel_a = '0;
    sel_b = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_a = sel_a | pa_val[i];
      sel_b = sel_b | pb_val[i];
    end
  end

  always_comb begin
    st_nxt = sir_pkg::ST_OK;
    case (req_r)
      sir_pkg::REQ_INSERT:  st_nxt = full ? sir_pkg::ST_FULL : sir_pkg::ST_OK;
      sir_pkg::REQ_READ:    st_nxt = (rank_w >= count_w) ? sir_pkg::ST_RANGE : sir_pkg::ST_OK;
      sir_pkg::REQ_AVERAGE: st_nxt = (rank1_w >= count_w) ? sir_pkg::ST_RANGE : sir_pkg::ST_OK;
      default:              st_nxt = sir_pkg::ST_OK;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        if (insert_en) count_nxt = count_r + CW'(1);
      end
      S_FIN: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // floor of the mean: 33-bit sum, arithmetic halving
  assign avg_sum   = {sel_a_r[sir_pkg::VALUE_W-1], sel_a_r} +
                     {sel_b_r[sir_pkg::VALUE_W-1], sel_b_r};
  assign count_ext = {{sir_pkg::COUNT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r    <= in_req_type;
      sample_r <= in_sample_value;
      rank_r   <= in_rank_index;
    end
    if (state_r == S_EXEC) begin
      st_r    <= st_nxt;
      sel_a_r <= sel_a;
      sel_b_r <= sel_b;
    end
    if (state_r == S_FIN) begin
      status_r <= st_r;
      ecount_r <= count_ext[sir_pkg::COUNT_W-1:0];
      result_r <= '0;
      if (st_r == sir_pkg::ST_OK) begin
        if (req_r == sir_pkg::REQ_READ) begin
          result_r <= sel_a_r;
        end else if (req_r == sir_pkg::REQ_AVERAGE) begin
          result_r <= avg_sum[sir_pkg::VALUE_W:1];
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = result_r;
  assign out_status_code  = status_r;
  assign out_entry_count  = ecount_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_w <= IW'(CAPACITY))
    else $error("stored count beyond capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == $past(count_r) + CW'(1)))
    else $error("stored count moved by other than one");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_FIN))
    else $error("result strobe without finishing transaction");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted transaction did not start");

endmodule
